// ===== design/mlp_forward_inference_core_assert.svh =====
// Assertion macros for the block's top-level file.
`ifndef MLP_FORWARD_INFERENCE_CORE_ASSERT_SVH
`define MLP_FORWARD_INFERENCE_CORE_ASSERT_SVH

// Two signals may never be high together.
`define MFI_ASSERT_EXCL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) !((a) && (b))) \
        else $error("mutually exclusive signals both high");

// A condition implies another in the next cycle.
`define MFI_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("expected follow-up condition missing");

// A condition implies another in the same cycle.
`define MFI_ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("implication violated");

`endif

// ===== design/mfi_pkg.sv =====
package mfi_pkg;

    localparam int MaxLayers = 4;
    localparam int MaxWidth  = 16;
    localparam int DataWidth = 16;

    localparam int LayerBits = $clog2(MaxLayers);
    localparam int IdxBits   = $clog2(MaxWidth);
    localparam int WAddrBits = LayerBits + 2 * IdxBits;
    localparam int BAddrBits = LayerBits + IdxBits;
    localparam int AccBits   = 2 * DataWidth + IdxBits + 1;

    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_INPUT  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_SIGMOID = 2'd0,
        ACT_RELU    = 2'd1,
        ACT_LINEAR  = 2'd2,
        ACT_STEP    = 2'd3
    } act_t;

    localparam logic [2:0] REG_LAYERS = 3'd0;
    localparam logic [2:0] REG_WIDTH0 = 3'd1;
    localparam logic [2:0] REG_WIDTH3 = 3'd4;
    localparam logic [2:0] REG_ACT    = 3'd5;

    // Control from sequencer to the MAC datapath.
    typedef struct packed {
        logic clear;   // start a new dot product
        logic mac;     // accumulate one product
        logic finish;  // form the neuron result
    } mac_ctl_t;

    function automatic logic [8:0] sig_tab(input logic [5:0] k);
        logic [8:0] t;
        case (k)
            6'd0: t = 9'd128;  6'd1: t = 9'd144;  6'd2: t = 9'd159;
            6'd3: t = 9'd174;  6'd4: t = 9'd187;  6'd5: t = 9'd199;
            6'd6: t = 9'd209;  6'd7: t = 9'd218;  6'd8: t = 9'd225;
            6'd9: t = 9'd232;  6'd10: t = 9'd237; 6'd11: t = 9'd241;
            6'd12: t = 9'd244; 6'd13: t = 9'd246; 6'd14: t = 9'd248;
            6'd15: t = 9'd250; 6'd16: t = 9'd251; 6'd17: t = 9'd252;
            6'd18: t = 9'd253; 6'd19: t = 9'd254; 6'd20: t = 9'd254;
            6'd21: t = 9'd255; 6'd22: t = 9'd255; 6'd23: t = 9'd255;
            6'd24: t = 9'd255;
            default: t = 9'd256;
        endcase
        return t;
    endfunction

    function automatic logic signed [DataWidth-1:0] activate(
        input act_t code, input logic signed [DataWidth-1:0] x);
        logic [DataWidth:0] m;
        logic [8:0] t0;
        logic [8:0] t1;
        logic [15:0] prod;
        logic [8:0] s;
        logic signed [DataWidth-1:0] r;
        m = x[DataWidth-1] ? (DataWidth+1)'(-$signed({x[DataWidth-1], x}))
                           : (DataWidth+1)'({1'b0, x});
        t0 = sig_tab(m[11:6]);
        t1 = sig_tab(6'(m[11:6] + 6'd1));
        prod = 16'(t1 - t0) * 16'(m[5:0]);
        if (m >= (DataWidth+1)'(2048)) begin
            s = 9'd256;
        end else begin
            s = 9'(t0 + 9'(prod >> 6));
        end
        case (code)
            ACT_SIGMOID: r = x[DataWidth-1] ? DataWidth'(9'd256 - s) : DataWidth'(s);
            ACT_RELU:    r = (x > 0) ? x : '0;
            ACT_LINEAR:  r = x;
            default:     r = x[DataWidth-1] ? '0 : DataWidth'(256);
        endcase
        return r;
    endfunction

endpackage

// ===== design/mfi_mac.sv =====
// Shared multiply-accumulate unit: one product per cycle, then scale, bias,
// saturate and, when act_en is set, activate in the finishing cycle.
module mfi_mac (
    input  logic                                 aclk,
    input  mfi_pkg::mac_ctl_t                    ctl,
    input  logic signed [mfi_pkg::DataWidth-1:0] x_in,
    input  logic signed [mfi_pkg::DataWidth-1:0] w_in,
    input  logic signed [mfi_pkg::DataWidth-1:0] b_in,
    input  logic                                 act_en,
    input  mfi_pkg::act_t                        act_code,
    output logic signed [mfi_pkg::DataWidth-1:0] y_out
);
    localparam int AB = mfi_pkg::AccBits;
    localparam int DW = mfi_pkg::DataWidth;

    logic signed [AB-1:0] acc_reg;
    logic signed [AB-1:0] acc_next;
    logic signed [AB-1:0] scaled;
    logic signed [DW-1:0] sat;
    logic signed [DW-1:0] y_reg;
    logic signed [DW-1:0] y_next;

    always_comb begin
        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (ctl.mac) begin
            acc_next = acc_reg + AB'(x_in * w_in);
        end
        // Arithmetic shift floors toward minus infinity.
        scaled = (acc_reg >>> 8) + AB'(b_in);
        if (scaled > AB'(signed'((1 << (DW - 1)) - 1))) begin
            sat = {1'b0, {(DW-1){1'b1}}};
        end else if (scaled < -AB'(signed'(1 << (DW - 1)))) begin
            sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sat = DW'(scaled);
        end
        y_next = act_en ? mfi_pkg::activate(act_code, sat) : sat;
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (ctl.finish) begin
            y_reg <= y_next;
        end
    end

    assign y_out = y_reg;
endmodule

// ===== design/mlp_forward_inference_core.sv =====
// Channel   | Dir | Payload
// s_axis    | in  | tdata: command, layer_index, row_index, column_index, value_in; tuser: last_in
// m_axis    | out | tdata: value_out, index_out; tlast: last_out
// cfg       | in  | register index and data
// Store writes and non-final input elements are taken without leaving idle.
// A final element runs each neuron through fetch, MAC, finish and store
// on the single shared MAC, fed by one weight-memory read a cycle.
// After reset all 1024 words of the weight memory are cleared, one word a
// cycle, while no item is accepted. Each result waits in an output register
// until taken; reset is synchronous and active low.
`include "mlp_forward_inference_core_assert.svh"
module mlp_forward_inference_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // command, layer_index, row_index, column_index, value_in
    input  logic        s_axis_tuser,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // value_out, index_out, zero fill
    output logic        m_axis_tlast,   // last_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int DW = mfi_pkg::DataWidth;
    localparam int IB = mfi_pkg::IdxBits;
    localparam int LB = mfi_pkg::LayerBits;
    localparam int WA = mfi_pkg::WAddrBits;
    localparam int BA = mfi_pkg::BAddrBits;
    localparam int WB = IB + 1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_FETCH, ST_MAC, ST_FIN, ST_STORE, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]    nl_reg;
    logic [WB-1:0] w_reg [mfi_pkg::MaxLayers];
    logic [7:0]    act_reg;

    logic signed [DW-1:0] wmem [2**WA];
    logic signed [DW-1:0] bmem [2**BA];
    logic signed [DW-1:0] bufa [mfi_pkg::MaxWidth];
    logic signed [DW-1:0] bufb [mfi_pkg::MaxWidth];
    logic signed [DW-1:0] bufc [mfi_pkg::MaxWidth];
    logic signed [DW-1:0] w_rd, b_rd, x_rd;

    logic [WA-1:0] clr_reg;
    logic [LB-1:0] li_reg;
    logic [IB-1:0] j_reg, k_reg;
    logic          src_b_reg;   // layer input comes from buffer b
    logic          src_c_reg;   // layer input comes from buffer c
    logic          klast_reg;   // the read issued last cycle was the final column
    logic          ovalid_reg;
    logic signed [DW-1:0] odata_reg;
    logic [IB-1:0] oidx_reg;
    logic          olast_reg;

    logic [1:0] cmd;
    logic [1:0] s_layer;
    logic [IB-1:0] s_row, s_col;
    logic signed [DW-1:0] s_val;
    logic s_acc;
    logic last_layer;
    logic [WB-1:0] wi, wo;
    mfi_pkg::mac_ctl_t ctl;
    logic signed [DW-1:0] y;

    assign cmd     = s_axis_tdata[1:0];
    assign s_layer = s_axis_tdata[3:2];
    assign s_row   = s_axis_tdata[7:4];
    assign s_col   = s_axis_tdata[11:8];
    assign s_val   = s_axis_tdata[27:12];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    assign last_layer = ({1'b0, li_reg} + 3'd1) == nl_reg;
    assign wo = w_reg[li_reg];
    assign wi = (li_reg == '0) ? w_reg[0] : w_reg[LB'(li_reg - 1'b1)];

    function automatic logic [WB-1:0] clampw(input logic [7:0] v);
        if (v == 8'd0) return WB'(1);
        if (v > 8'(mfi_pkg::MaxWidth)) return WB'(mfi_pkg::MaxWidth);
        return WB'(v);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nl_reg  <= 3'd1;
            for (int i = 0; i < mfi_pkg::MaxLayers; i++) w_reg[i] <= WB'(mfi_pkg::MaxWidth);
            act_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == mfi_pkg::REG_LAYERS) begin
                nl_reg <= (cfg_data[2:0] == 3'd0) ? 3'd1 :
                          (cfg_data[2:0] > 3'(mfi_pkg::MaxLayers)) ?
                          3'(mfi_pkg::MaxLayers) : cfg_data[2:0];
            end else if (cfg_index >= mfi_pkg::REG_WIDTH0 && cfg_index <= mfi_pkg::REG_WIDTH3) begin
                w_reg[LB'(cfg_index - mfi_pkg::REG_WIDTH0)] <= clampw({3'd0, cfg_data[4:0]});
            end else if (cfg_index == mfi_pkg::REG_ACT) begin
                act_reg <= cfg_data;
            end
        end
    end

    // Memories: weight and bias read registered at the fetch address.
    // Hidden layers alternate between buffers b and c, so the input vector
    // in buffer a survives a run.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            wmem[clr_reg] <= '0;
        end else if (s_acc && cmd == mfi_pkg::CMD_WEIGHT) begin
            wmem[{s_layer, s_row, s_col}] <= s_val;
        end
        w_rd <= wmem[{li_reg, j_reg, k_reg}];
        x_rd <= src_b_reg ? bufb[k_reg] : (src_c_reg ? bufc[k_reg] : bufa[k_reg]);
        if (s_acc && cmd == mfi_pkg::CMD_BIAS) begin
            bmem[{s_layer, s_row}] <= s_val;
        end
        b_rd <= bmem[{li_reg, j_reg}];
        if (s_acc && cmd == mfi_pkg::CMD_INPUT) begin
            bufa[s_col] <= s_val;
        end
        if (state_reg == ST_STORE) begin
            if (src_b_reg) bufc[j_reg] <= y;
            else bufb[j_reg] <= y;
        end
    end

    // Bias store is small: cleared by flops through a valid mask.
    logic [2**BA-1:0] bval_reg;
    logic signed [DW-1:0] b_eff;
    logic bv_rd;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bval_reg <= '0;
        end else if (s_acc && cmd == mfi_pkg::CMD_BIAS) begin
            bval_reg[{s_layer, s_row}] <= 1'b1;
        end
        bv_rd <= bval_reg[{li_reg, j_reg}];
    end
    assign b_eff = bv_rd ? b_rd : '0;

    always_comb begin
        ctl = '0;
        ctl.clear  = (state_reg == ST_FETCH);
        ctl.mac    = (state_reg == ST_MAC);
        ctl.finish = (state_reg == ST_FIN);
    end

    mfi_mac u_mac (
        .aclk(aclk), .ctl(ctl), .x_in(x_rd), .w_in(w_rd), .b_in(b_eff),
        .act_en(!last_layer),
        .act_code(mfi_pkg::act_t'(act_reg[{li_reg, 1'b0} +: 2])),
        .y_out(y)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE:  if (s_acc && cmd == mfi_pkg::CMD_INPUT && s_axis_tuser) state_next = ST_FETCH;
            ST_FETCH: state_next = ST_MAC;
            ST_MAC:   if (klast_reg) state_next = ST_FIN;
            ST_FIN:   state_next = ST_STORE;
            ST_STORE: begin
                if ({1'b0, j_reg} + 1'b1 != wo) state_next = ST_FETCH;
                else if (last_layer) state_next = ST_OUT;
                else state_next = ST_FETCH;
            end
            ST_OUT: if (!ovalid_reg || m_axis_tready) begin
                if (olast_reg && ovalid_reg && m_axis_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            li_reg     <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            src_b_reg  <= 1'b0;
            src_c_reg  <= 1'b0;
            klast_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            klast_reg <= ({1'b0, k_reg} + 1'b1 == wi);
            case (state_reg)
                ST_CLEAR: clr_reg <= WA'(clr_reg + 1'b1);
                ST_IDLE: begin
                    li_reg <= '0; j_reg <= '0; k_reg <= '0; src_b_reg <= 1'b0;
                    src_c_reg <= 1'b0;
                    olast_reg <= 1'b0;
                end
                ST_FETCH: k_reg <= ({1'b0, k_reg} + 1'b1 == wi) ? k_reg : IB'(k_reg + 1'b1);
                ST_MAC: if ({1'b0, k_reg} + 1'b1 != wi) k_reg <= IB'(k_reg + 1'b1);
                ST_FIN: ;
                ST_STORE: begin
                    k_reg <= '0;
                    if ({1'b0, j_reg} + 1'b1 != wo) begin
                        j_reg <= IB'(j_reg + 1'b1);
                    end else begin
                        j_reg <= '0;
                        if (!last_layer) begin
                            li_reg <= LB'(li_reg + 1'b1);
                            src_b_reg <= !src_b_reg;
                            src_c_reg <= src_b_reg;
                        end else begin
                            // Results now sit in the buffer just written.
                            src_b_reg <= !src_b_reg;
                            src_c_reg <= src_b_reg;
                        end
                    end
                end
                ST_OUT: begin
                    if ((!ovalid_reg || m_axis_tready) && !olast_reg) begin
                        ovalid_reg <= 1'b1;
                        odata_reg  <= src_b_reg ? bufb[j_reg] :
                                      (src_c_reg ? bufc[j_reg] : bufa[j_reg]);
                        oidx_reg   <= j_reg;
                        olast_reg  <= ({1'b0, j_reg} + 1'b1 == wo);
                        j_reg      <= IB'(j_reg + 1'b1);
                    end else if (ovalid_reg && m_axis_tready) begin
                        ovalid_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // The pipeline reads x and w registered, in the cycle after the address: the fetch state
    // presents k = 0, and the MAC states consume it with k advanced.
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'd0, oidx_reg, odata_reg};
    assign m_axis_tlast  = olast_reg;

    `MFI_ASSERT_EXCL(a_no_accept_busy, aclk, aresetn, s_axis_tready, m_axis_tvalid)
    `MFI_ASSERT_IMPL(a_out_in_out_state, aclk, aresetn, m_axis_tvalid, state_reg == ST_OUT)
    `MFI_ASSERT_NEXT(a_last_ends, aclk, aresetn,
        m_axis_tvalid && m_axis_tready && m_axis_tlast, state_reg == ST_IDLE)
endmodule

// ===== tb/mlp_forward_inference_core_tb.sv =====
module mlp_forward_inference_core_tb;

    typedef struct packed {
        logic        last;
        logic [15:0] value;
        logic [3:0]  col;
        logic [3:0]  row;
        logic [1:0]  layer;
        mfi_pkg::cmd_t cmd;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] value;
        logic [3:0]  index;
        logic        last;
    } out_elem_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    mlp_forward_inference_core uut (.*);

    always #1 aclk = ~aclk;

    // Predictor state.
    int          net_layers;
    int          net_width[4];
    logic [7:0]  net_act;
    logic signed [15:0] wmem[1024];
    logic signed [15:0] bmem[64];
    logic signed [15:0] vec_in[16];

    cmd_item_t   pending_items[$];
    out_elem_t   expected_outputs[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          driver_busy = 1'b0;
    bit          s_taken = 1'b0;

    function automatic int clamp_w(int w);
        if (w < 1) return 1;
        if (w > 16) return 16;
        return w;
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] apply_act(mfi_pkg::act_t code,
                                                     logic signed [15:0] x);
        int tab[33] = '{128, 144, 159, 174, 187, 199, 209, 218, 225, 232, 237,
                        241, 244, 246, 248, 250, 251, 252, 253, 254, 254, 255,
                        255, 255, 255, 256, 256, 256, 256, 256, 256, 256, 256};
        int m;
        int s;
        int xi;
        xi = x;
        case (code)
            mfi_pkg::ACT_SIGMOID: begin
                m = xi < 0 ? -xi : xi;
                if (m >= 2048) s = 256;
                else s = tab[m >> 6] + (((tab[(m >> 6) + 1] - tab[m >> 6]) * (m & 63)) >>> 6);
                return 16'(xi < 0 ? 256 - s : s);
            end
            mfi_pkg::ACT_RELU:   return xi > 0 ? x : 16'sd0;
            mfi_pkg::ACT_LINEAR: return x;
            default:             return xi >= 0 ? 16'sd256 : 16'sd0;
        endcase
    endfunction

    task automatic predict_network(cmd_item_t it);
        logic signed [15:0] cur[16];
        logic signed [15:0] nxt[16];
        int nl;
        int wi;
        int wo;
        longint acc;
        longint q;
        out_elem_t e;
        case (it.cmd)
            mfi_pkg::CMD_WEIGHT: wmem[{it.layer, it.row, it.col}] = it.value;
            mfi_pkg::CMD_BIAS:   bmem[{it.layer, it.row}] = it.value;
            mfi_pkg::CMD_INPUT: begin
                vec_in[it.col] = it.value;
                if (it.last) begin
                    nl = net_layers < 1 ? 1 : (net_layers > 4 ? 4 : net_layers);
                    cur = vec_in;
                    wi = clamp_w(net_width[0]);
                    wo = wi;
                    for (int i = 0; i < nl; i++) begin
                        wo = clamp_w(net_width[i]);
                        for (int j = 0; j < wo; j++) begin
                            acc = 0;
                            for (int k = 0; k < wi; k++)
                                acc += longint'(cur[k]) * longint'(wmem[i * 256 + j * 16 + k]);
                            q = acc >>> 8;
                            q += bmem[i * 16 + j];
                            nxt[j] = sat16(q);
                            if (i + 1 < nl)
                                nxt[j] = apply_act(mfi_pkg::act_t'(net_act[2 * i +: 2]),
                                                   nxt[j]);
                        end
                        for (int j = 0; j < wo; j++) cur[j] = nxt[j];
                        wi = wo;
                    end
                    for (int j = 0; j < wo; j++) begin
                        e.value = cur[j];
                        e.index = 4'(j);
                        e.last  = (j + 1 == wo);
                        expected_outputs.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Driver: one item from the queue at a time, with random gaps.
    always @(negedge aclk) begin
        cmd_item_t it;
        if (aresetn) begin
            if (s_axis_tvalid && !s_taken) begin
                // hold the item
            end else if (pending_items.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                it = pending_items.pop_front();
                predict_network(it);
                s_axis_tdata  <= {4'b0, it.value, it.col, it.row, it.layer, it.cmd};
                s_axis_tuser  <= it.last;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            driver_busy <= (pending_items.size() > 0) ||
                           (s_axis_tvalid && !s_axis_tready);
            s_taken     <= s_axis_tvalid && s_axis_tready;
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        out_elem_t got;
        out_elem_t exp_e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.value = m_axis_tdata[15:0];
            got.index = m_axis_tdata[19:16];
            got.last  = m_axis_tlast;
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: value %h index %0d last %0b",
                             got.value, got.index, got.last);
            end else begin
                exp_e = expected_outputs.pop_front();
                if (got !== exp_e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("output mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                                 exp_e.value, exp_e.index, exp_e.last,
                                 got.value, got.index, got.last);
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            mfi_pkg::REG_LAYERS: net_layers = val & 7;
            mfi_pkg::REG_ACT:    net_act = val;
            default: if (idx >= mfi_pkg::REG_WIDTH0 && idx <= mfi_pkg::REG_WIDTH3)
                         net_width[idx - mfi_pkg::REG_WIDTH0] = val & 31;
        endcase
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (pending_items.size() > 0 || driver_busy || s_axis_tvalid ||
               expected_outputs.size() > 0)
            @(posedge aclk);
        // A store write can still be in flight after the last output.
        repeat (20) @(posedge aclk);
    endtask

    function automatic cmd_item_t mk(mfi_pkg::cmd_t c, int l, int r, int k, int v, bit lst);
        cmd_item_t it;
        it.cmd = c; it.layer = 2'(l); it.row = 4'(r); it.col = 4'(k);
        it.value = 16'(v); it.last = lst;
        return it;
    endfunction

    // Fills the whole input vector of the current width, the last one marked.
    task automatic queue_vector(int w, bit extreme);
        for (int k = 0; k < w; k++)
            pending_items.push_back(mk(mfi_pkg::CMD_INPUT, 0, 0, k,
                extreme ? ($urandom_range(1) ? 32'h7fff : 32'h8000)
                        : $urandom_range(16'hffff), k == w - 1));
    endtask

    task automatic set_net(int nl, int w0, int w1, int w2, int w3, int act);
        write_reg(mfi_pkg::REG_LAYERS, 8'(nl));
        write_reg(mfi_pkg::REG_WIDTH0, 8'(w0));
        write_reg(3'(mfi_pkg::REG_WIDTH0 + 1), 8'(w1));
        write_reg(3'(mfi_pkg::REG_WIDTH0 + 2), 8'(w2));
        write_reg(mfi_pkg::REG_WIDTH3, 8'(w3));
        write_reg(mfi_pkg::REG_ACT, 8'(act));
    endtask

    initial begin
        int w;
        net_layers = 1;
        for (int i = 0; i < 4; i++) net_width[i] = 16;
        net_act = '0;
        for (int i = 0; i < 1024; i++) wmem[i] = '0;
        for (int i = 0; i < 64; i++) bmem[i] = '0;
        for (int i = 0; i < 16; i++) vec_in[i] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: full-width reset network, then extremes and every activation.
        queue_vector(16, 1'b0);
        wait_idle();
        set_net(2, 2, 3, 1, 1, 8'h00);
        pending_items.push_back(mk(mfi_pkg::CMD_WEIGHT, 0, 0, 0, 16'h7fff, 1'b1));
        pending_items.push_back(mk(mfi_pkg::CMD_WEIGHT, 0, 1, 1, 16'h8000, 1'b0));
        pending_items.push_back(mk(mfi_pkg::CMD_WEIGHT, 0, 0, 1, 16'h0100, 1'b0));
        pending_items.push_back(mk(mfi_pkg::CMD_BIAS, 0, 1, 0, 16'h7fff, 1'b0));
        pending_items.push_back(mk(mfi_pkg::CMD_BIAS, 0, 0, 0, 16'h8000, 1'b0));
        pending_items.push_back(mk(mfi_pkg::CMD_BIAS, 3, 15, 15, 16'h1234, 1'b1));
        pending_items.push_back(mk(mfi_pkg::CMD_WEIGHT, 3, 15, 15, 16'hffff, 1'b0));
        pending_items.push_back(mk(mfi_pkg::CMD_NONE, 3, 15, 15, 16'hffff, 1'b1));
        for (int j = 0; j < 3; j++)
            for (int k = 0; k < 2; k++)
                pending_items.push_back(mk(mfi_pkg::CMD_WEIGHT, 1, j, k,
                                           $urandom_range(16'hffff), 1'b0));
        pending_items.push_back(mk(mfi_pkg::CMD_INPUT, 0, 0, 0, 16'h7fff, 1'b0));
        pending_items.push_back(mk(mfi_pkg::CMD_INPUT, 0, 0, 1, 16'h8000, 1'b1));
        // Position beyond the vector still starts a run; stale elements are reused.
        pending_items.push_back(mk(mfi_pkg::CMD_INPUT, 0, 0, 15, 16'h0080, 1'b1));
        wait_idle();
        for (int a = 1; a < 4; a++) begin
            write_reg(mfi_pkg::REG_ACT, 8'(a * 8'h55));
            queue_vector(2, 1'b1);
            wait_idle();
        end
        // Out-of-range register values saturate.
        set_net(0, 0, 31, 31, 31, 8'hff);
        queue_vector(1, 1'b0);
        wait_idle();
        set_net(7, 17, 16, 16, 16, 8'h1b);
        queue_vector(16, 1'b0);
        wait_idle();

        // Random: small networks mostly, two phases per idling mode.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            w = $urandom_range(1, 4);
            set_net($urandom_range(1, 4), w, $urandom_range(1, 4), $urandom_range(1, 4),
                    (phase == 7) ? 16 : $urandom_range(1, 4), $urandom_range(255));
            for (int n = 0; n < 5; n++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: pending_items.push_back(mk(mfi_pkg::CMD_WEIGHT,
                        $urandom_range(3), $urandom_range(3), $urandom_range(3),
                        $urandom_range(16'hffff), 1'($urandom_range(1))));
                    4, 5: pending_items.push_back(mk(mfi_pkg::CMD_BIAS, $urandom_range(3),
                        $urandom_range(15), $urandom_range(15), $urandom_range(16'hffff),
                        1'($urandom_range(1))));
                    6: pending_items.push_back(mk(mfi_pkg::cmd_t'($urandom_range(3)),
                        $urandom_range(3), $urandom_range(15), $urandom_range(15),
                        $urandom_range(16'hffff), 1'b0));
                    default: queue_vector(w, $urandom_range(3) == 0);
                endcase
            end
            queue_vector(w, 1'b0);
            wait_idle();
        end

        if (mismatches == 0 && expected_outputs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end
endmodule
